// ===== rtl/core/lsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// lsfe_pkg
// shared types, constants and palette helpers for the led strip frame encoder
// ----------------------------------------------------------------------------
package lsfe_pkg;

	localparam int COLOR_W = 4;
	localparam int LEVEL_W = 9;
	localparam int MODE_W  = 2;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [LEVEL_W-1:0] level;
	} pixel_t;

	// input modes
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FILL  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HILITE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_EMIT  = 2'd3;

	localparam logic [COLOR_W-1:0] RED_INDEX   = 4'd4;
	localparam logic [COLOR_W-1:0] BLACK_INDEX = 4'd0;
	localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 9'd256;

	localparam int HEAD_BYTES = 4;
	localparam int TAIL_BYTES = 4;

	localparam logic [7:0] START_BYTE = 8'h00;
	localparam logic [7:0] MARK_BYTE  = 8'hFF;

	// palette as {red, green, blue}
	function automatic logic [23:0] lsfe_pal(input logic [COLOR_W-1:0] c);
		logic [23:0] rgb;
		case (c)
			4'd1:    rgb = 24'hFF_FF_FF;
			4'd2:    rgb = 24'h00_00_FF;
			4'd3:    rgb = 24'h00_FF_00;
			4'd4:    rgb = 24'hFF_00_00;
			4'd5:    rgb = 24'hC0_FF_00;
			4'd6:    rgb = 24'h80_20_00;
			4'd7:    rgb = 24'h80_20_10;
			4'd8:    rgb = 24'hFF_00_10;
			4'd9:    rgb = 24'h00_FD_FF;
			default: rgb = 24'h00_00_00;
		endcase
		return rgb;
	endfunction

	function automatic logic [7:0] lsfe_flip8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	// channel * level >> 8, saturated to 8 bits
	function automatic logic [7:0] lsfe_scale(input logic [7:0] ch,
	                                         input logic [LEVEL_W-1:0] lvl);
		logic [16:0] prod;
		logic [8:0]  shifted;
		prod    = 17'(ch) * 17'(lvl);
		shifted = prod[16:8];
		return shifted[8] ? 8'hFF : shifted[7:0];
	endfunction

endpackage

// ===== rtl/core/lsfe_ram.sv =====
// ----------------------------------------------------------------------------
// lsfe_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lsfe_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/led_strip_frame_encoder_top.sv =====
// ----------------------------------------------------------------------------
// led_strip_frame_encoder_top
// pixel store and serial frame byte generator for an apa102 style led strip
// ----------------------------------------------------------------------------
// The block keeps STRIP_LENGTH pixels (palette index plus unsigned Q8
// intensity, 256 = full) in one synchronous ram and hands out the strip frame
// one byte per mode 3 beat: four 0x00 start bytes, then per pixel 0xFF and the
// bit-reversed blue, green and red levels, then four 0xFF end bytes, the last
// of them flagged by frame_last. Only mode 3 beats produce an output beat.
// A pixel write goes straight to the ram from the idle state; a highlight step
// and a frame byte each pass through a further state, as the pixel ram read is
// registered (read, then modify and write or format); a fill runs the sweep,
// which writes the ram one pixel per cycle. After reset the same sweep
// clears the store to color 0 at full intensity, and in_ready stays low
// until it ends. A finished byte waits in the output register, so the next
// input beat can be taken while it is pending; a second byte waits in the
// format stage until the first one is taken.
module led_strip_frame_encoder_top #(
	parameter int STRIP_LENGTH = 64,
	parameter int PALETTE_SIZE = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [5:0] position,
	input  logic [3:0] color,
	input  logic [8:0] intensity,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_last
);

	import lsfe_pkg::*;

	localparam int ADDR_W      = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;
	localparam int CUR_W       = $clog2(STRIP_LENGTH + 1);
	localparam int FRAME_BYTES = HEAD_BYTES + 4 * STRIP_LENGTH + TAIL_BYTES;
	localparam int BP_W        = $clog2(FRAME_BYTES);

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HILITE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RG_HEAD,
		RG_PIXEL,
		RG_TAIL
	} region_t;

	state_t              state_q;
	region_t             region_q;
	logic [1:0]          lane_q;
	logic                last_q;
	logic [ADDR_W-1:0]   sweep_cnt_q;
	pixel_t              fill_q;
	pixel_t              saved_q;
	logic [CUR_W-1:0]    cursor_q;
	logic [BP_W-1:0]     byte_ptr_q;
	logic [ADDR_W-1:0]   hl_addr_q;
	logic [LEVEL_W-1:0]  hl_level_q;
	logic                hl_same_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                frame_last_q;

	// ram ports
	logic                ram_wr_en;
	logic [ADDR_W-1:0]   ram_wr_addr;
	pixel_t              ram_wr_data;
	logic                ram_rd_en;
	logic [ADDR_W-1:0]   ram_rd_addr;
	pixel_t              ram_rd_data;

	// input side decode
	logic                accept;
	logic                pos_ok;
	logic                cursor_ok;
	logic                same_pos;
	logic [ADDR_W-1:0]   pos_addr;
	logic [COLOR_W-1:0]  clean_color;
	logic [BP_W-1:0]     pix_off;
	region_t             region_now;

	// format stage
	logic [COLOR_W-1:0]  shown_color;
	logic [23:0]         rgb;
	logic [7:0]          channel;
	logic [7:0]          fmt_byte;
	logic                out_free;

	assign accept      = in_valid && in_ready;
	assign in_ready    = (state_q == ST_IDLE);
	assign pos_ok      = int'(position) < STRIP_LENGTH;
	assign cursor_ok   = int'(cursor_q) < STRIP_LENGTH;
	assign same_pos    = int'(position) == int'(cursor_q);
	assign pos_addr    = ADDR_W'(position);
	assign clean_color = (5'(color) >= 5'(PALETTE_SIZE)) ? BLACK_INDEX : color;
	assign pix_off     = byte_ptr_q - BP_W'(HEAD_BYTES);
	assign out_free    = !out_valid_q || out_ready;

	always_comb begin
		if (byte_ptr_q < BP_W'(HEAD_BYTES)) begin
			region_now = RG_HEAD;
		end else if (byte_ptr_q < BP_W'(HEAD_BYTES + 4 * STRIP_LENGTH)) begin
			region_now = RG_PIXEL;
		end else begin
			region_now = RG_TAIL;
		end
	end

	// single write port: sweep, direct write, cursor restore, highlight paint
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = sweep_cnt_q;
		ram_wr_data = fill_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = pos_addr;
		case (state_q)
			ST_SWEEP: begin
				ram_wr_en = 1'b1;
			end
			ST_IDLE: begin
				if (accept && mode == MODE_WRITE && pos_ok) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = pos_addr;
					ram_wr_data = '{color: clean_color, level: intensity};
				end
				if (accept && mode == MODE_HILITE && pos_ok) begin
					// fetch the target pixel, put the old one back in parallel
					ram_rd_en   = 1'b1;
					ram_wr_en   = !same_pos && cursor_ok;
					ram_wr_addr = ADDR_W'(cursor_q);
					ram_wr_data = saved_q;
				end
				if (accept && mode == MODE_EMIT && region_now == RG_PIXEL) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = pix_off[ADDR_W+1:2];
				end
			end
			ST_HILITE: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = hl_addr_q;
				ram_wr_data = hl_same_q ? pixel_t'{color: ram_rd_data.color, level: hl_level_q}
				                        : pixel_t'{color: RED_INDEX, level: hl_level_q};
			end
			default: begin
			end
		endcase
	end

	// byte formatting from the pixel read back
	always_comb begin
		shown_color = (5'(ram_rd_data.color) >= 5'(PALETTE_SIZE)) ? BLACK_INDEX
		                                                          : ram_rd_data.color;
		rgb = lsfe_pal(shown_color);
		case (lane_q)
			2'd1:    channel = rgb[7:0];
			2'd2:    channel = rgb[15:8];
			default: channel = rgb[23:16];
		endcase
		case (region_q)
			RG_HEAD:  fmt_byte = START_BYTE;
			RG_PIXEL: fmt_byte = (lane_q == 2'd0) ? MARK_BYTE
			                                      : lsfe_flip8(lsfe_scale(channel,
			                                                   ram_rd_data.level));
			default:  fmt_byte = MARK_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_cnt_q  <= '0;
			fill_q       <= '{color: BLACK_INDEX, level: FULL_LEVEL};
			saved_q      <= '0;
			cursor_q     <= CUR_W'(STRIP_LENGTH);
			byte_ptr_q   <= '0;
			out_valid_q  <= 1'b0;
			region_q     <= RG_HEAD;
			lane_q       <= '0;
			last_q       <= 1'b0;
			hl_addr_q    <= '0;
			hl_level_q   <= '0;
			hl_same_q    <= 1'b0;
			out_byte_q   <= '0;
			frame_last_q <= 1'b0;
		end else begin
			// the format stage reloads the output register itself
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (sweep_cnt_q == ADDR_W'(STRIP_LENGTH - 1)) begin
						sweep_cnt_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						sweep_cnt_q <= sweep_cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_FILL: begin
								fill_q      <= '{color: clean_color, level: intensity};
								sweep_cnt_q <= '0;
								state_q     <= ST_SWEEP;
							end
							MODE_HILITE: begin
								if (pos_ok) begin
									hl_addr_q  <= pos_addr;
									hl_level_q <= intensity;
									hl_same_q  <= same_pos;
									cursor_q   <= CUR_W'(position);
									state_q    <= ST_HILITE;
								end
							end
							MODE_EMIT: begin
								region_q <= region_now;
								lane_q   <= pix_off[1:0];
								if (byte_ptr_q == BP_W'(FRAME_BYTES - 1)) begin
									last_q     <= 1'b1;
									byte_ptr_q <= '0;
								end else begin
									last_q     <= 1'b0;
									byte_ptr_q <= byte_ptr_q + 1'b1;
								end
								state_q <= ST_EMIT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_HILITE: begin
					// keep the pixel that the cursor covers for later restore
					if (!hl_same_q) begin
						saved_q <= ram_rd_data;
					end
					state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_byte_q   <= fmt_byte;
						frame_last_q <= last_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	lsfe_ram #(
		.WIDTH ($bits(pixel_t)),
		.DEPTH (STRIP_LENGTH)
	) u_pixel_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign frame_last = frame_last_q;

	// the cursor restore must never hit the pixel being fetched
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
		else $error("pixel ram read and write at the same entry");

	// closing byte of a frame is always an end-frame byte
	a_last_is_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_last_q |-> out_byte_q == MARK_BYTE)
		else $error("frame_last on a byte other than the end frame");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ptr_q <= BP_W'(FRAME_BYTES - 1))
		else $error("byte pointer past end of frame");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cursor_q) <= STRIP_LENGTH)
		else $error("cursor outside strip");

	// a pending byte is never overwritten by the format stage
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_valid_q && !out_ready |=> state_q == ST_EMIT)
		else $error("format stage left while output beat still pending");

endmodule
